FILE: hdl/bdq_pkg.sv
// Shared types, constants and the ring helper for the bounded deque.
`timescale 1ns / 1ps
package bdq_pkg;

  // Ring geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;

  // Request modes
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_DUMP       = 3'd4;

  // Response status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
  } bdq_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] item;
    logic                     last;
  } bdq_rsp_t;

  // Slot memory access from the sequencer
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } bdq_ram_ctl_t;

  // Ring position base + offset, offset no larger than DEPTH
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offs);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

FILE: hdl/bounded_deque_core.sv
// Top level of the bounded deque: sequencer plus slot memory.
`timescale 1ns / 1ps
// Bounded double-ended queue of DEPTH (64) signed 32-bit values kept in a ring
// in one synchronous RAM. Each request pushes at the front or back, pops from
// the front or back, or dumps the contents front to back; unused mode codes
// are dropped without a response. A push answers ok or full. A pop answers
// with the removed value or empty status; the value goes from the registered
// RAM read through S_POP into the response register. A dump of N values
// streams one response per cycle through the single RAM read port while the
// output is not stalled, with last set on the final one; an empty dump answers
// once with empty status. Responses leave through one output register; a new
// request is taken only while the sequencer is idle and that register is
// empty or being read out, so a stalled response holds off the input. No
// clearing pass is needed after reset: only occupied slots are ever read.
module bounded_deque_core
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  bdq_req_t req,
  input  logic     req_valid,
  output logic     req_ready,
  output bdq_rsp_t rsp,
  output logic     rsp_valid,
  input  logic     rsp_ready
);

  bdq_ram_ctl_t      ram_ctl;
  logic [DATA_W-1:0] ram_rdata;

  bdq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .ram_ctl   (ram_ctl),
    .ram_rdata (ram_rdata)
  );

  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (ram_ctl.wdata),
    .re    (ram_ctl.re),
    .raddr (ram_ctl.raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: hdl/bdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read ports; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bdq_seq.sv
// Sequencer: ring pointers, slot memory access and the response register.
`timescale 1ns / 1ps
module bdq_seq
  import bdq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  bdq_req_t          req,
  input  logic              req_valid,
  output logic              req_ready,
  output bdq_rsp_t          rsp,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bdq_ram_ctl_t      ram_ctl,
  input  logic [DATA_W-1:0] ram_rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] front;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] idx;

  logic              out_free;
  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic              is_push;
  logic              is_read;
  logic              dump_last;
  logic              dump_step;
  logic [CNT_W-1:0]  idx_inc;
  logic [ADDR_W-1:0] front_dec;
  logic [ADDR_W-1:0] back_pos;
  logic [ADDR_W-1:0] tail_pos;
  logic [ADDR_W-1:0] dump_pos;

  // Decode the handshake and ring positions
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign accept    = req_valid && req_ready;
  assign is_full   = (count == CNT_W'(DEPTH));
  assign is_empty  = (count == '0);
  assign is_push   = (req.mode == MODE_PUSH_FRONT) || (req.mode == MODE_PUSH_BACK);
  assign is_read   = (req.mode == MODE_POP_FRONT) || (req.mode == MODE_POP_BACK) ||
                     (req.mode == MODE_DUMP);
  assign idx_inc   = CNT_W'(idx) + CNT_W'(1);
  assign dump_last = (idx_inc == count);
  assign dump_step = (state == S_DUMP) && out_free;
  assign front_dec = (front == '0) ? ADDR_W'(DEPTH - 1) : front - ADDR_W'(1);
  assign back_pos  = ring_add(front, count);
  assign tail_pos  = ring_add(front, count - CNT_W'(1));
  assign dump_pos  = ring_add(front, idx_inc);

  // Drive the slot memory
  always_comb begin
    ram_ctl.we    = accept && is_push && !is_full;
    ram_ctl.waddr = (req.mode == MODE_PUSH_FRONT) ? front_dec : back_pos;
    ram_ctl.wdata = req.value;
    ram_ctl.re    = (accept && is_read && !is_empty) || (dump_step && !dump_last);
    if (state == S_DUMP) begin
      ram_ctl.raddr = dump_pos;
    end else if (req.mode == MODE_POP_BACK) begin
      ram_ctl.raddr = tail_pos;
    end else begin
      ram_ctl.raddr = front;
    end
  end

  // Hold state, pointers and the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.mode)
              MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                rsp_valid  <= 1'b1;
                rsp.item   <= '0;
                rsp.last   <= 1'b1;
                if (is_full) begin
                  rsp.status <= ST_FULL;
                end else begin
                  rsp.status <= ST_OK;
                  count      <= count + CNT_W'(1);
                  if (req.mode == MODE_PUSH_FRONT) begin
                    front <= front_dec;
                  end
                end
              end
              MODE_POP_FRONT, MODE_POP_BACK: begin
                if (is_empty) begin
                  rsp_valid  <= 1'b1;
                  rsp.status <= ST_EMPTY;
                  rsp.item   <= '0;
                  rsp.last   <= 1'b1;
                end else begin
                  count <= count - CNT_W'(1);
                  if (req.mode == MODE_POP_FRONT) begin
                    front <= ring_add(front, CNT_W'(1));
                  end
                  state <= S_POP;
                end
              end
              MODE_DUMP: begin
                if (is_empty) begin
                  rsp_valid  <= 1'b1;
                  rsp.status <= ST_EMPTY;
                  rsp.item   <= '0;
                  rsp.last   <= 1'b1;
                end else begin
                  idx   <= '0;
                  state <= S_DUMP;
                end
              end
              default: begin
                // drop unused modes
              end
            endcase
          end
        end
        S_POP: begin
          // register was emptied at accept time
          rsp_valid  <= 1'b1;
          rsp.status <= ST_OK;
          rsp.item   <= ram_rdata;
          rsp.last   <= 1'b1;
          state      <= S_IDLE;
        end
        S_DUMP: begin
          if (out_free) begin
            rsp_valid  <= 1'b1;
            rsp.status <= ST_OK;
            rsp.item   <= ram_rdata;
            rsp.last   <= dump_last;
            if (dump_last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx_inc[ADDR_W-1:0];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
